// ===== rtl/salc_pkg.sv =====
// Shared constants and types of the set-associative LRU cache tag store.
// Used by salc_pick and set_assoc_lru_cache_tags_unit; depends on nothing.
`default_nettype none

package salc_pkg;

  localparam int SETS       = 64;
  localparam int WAYS       = 4;
  localparam int TAG_BITS   = 20;
  localparam int STAMP_BITS = 32;
  localparam int CFG_BITS   = 3;

  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [CFG_BITS-1:0] WAYS_RESET = CFG_BITS'(4);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // One way of a set as held in the tag memory.
  typedef struct packed {
    logic                  dirty;
    logic [TAG_BITS-1:0]   tag;
    logic [STAMP_BITS-1:0] stamp;
  } line_t;

  localparam int LINE_BITS = $bits(line_t);
  localparam int ROW_BITS  = LINE_BITS * WAYS;

  typedef line_t [WAYS-1:0] row_t;

  // Outcome of the way search for one transaction.
  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                victim_valid;
  } pick_t;

endpackage

`default_nettype wire

// ===== rtl/salc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/salc_pick.sv =====
// Way search of one set: hit detection, lowest invalid way and oldest stamp.
// Depends on salc_pkg.
`default_nettype none

module salc_pick (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire salc_pkg::row_t                 row_i,
  input  wire logic [salc_pkg::WAYS-1:0]      valid_i,
  input  wire logic [salc_pkg::CFG_BITS-1:0]  active_i,
  input  wire logic [salc_pkg::TAG_BITS-1:0]  tag_i,
  output salc_pkg::pick_t                     pick_o
);

  logic                            hit;
  logic [salc_pkg::WAY_BITS-1:0]   hit_way;
  logic                            found_inv;
  logic [salc_pkg::WAY_BITS-1:0]   inv_way;
  logic [salc_pkg::WAY_BITS-1:0]   old_way;
  logic [salc_pkg::STAMP_BITS-1:0] best;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    found_inv = 1'b0;
    inv_way   = '0;
    old_way   = '0;
    best      = row_i[0].stamp;
    for (int w = 0; w < salc_pkg::WAYS; w++) begin
      if (w < int'(active_i)) begin
        if (!hit && valid_i[w] && row_i[w].tag == tag_i) begin
          hit     = 1'b1;
          hit_way = salc_pkg::WAY_BITS'(w);
        end
        if (!found_inv && !valid_i[w]) begin
          found_inv = 1'b1;
          inv_way   = salc_pkg::WAY_BITS'(w);
        end
        // Strict compare keeps the lowest way among equal stamps.
        if (w > 0 && row_i[w].stamp < best) begin
          best    = row_i[w].stamp;
          old_way = salc_pkg::WAY_BITS'(w);
        end
      end
    end
    pick_o.hit          = hit;
    pick_o.way          = hit ? hit_way : (found_inv ? inv_way : old_way);
    pick_o.victim_valid = !found_inv;
  end

  // The chosen way always lies inside the searched range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_i != '0 |-> int'(pick_o.way) < int'(active_i))
    else $error("salc_pick: chosen way outside the active ways");

  // A hit way is always valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_o.hit |-> valid_i[pick_o.way])
    else $error("salc_pick: hit on an invalid way");

  // A miss into an invalid way never picks a valid one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pick_o.hit && !pick_o.victim_valid) |-> !valid_i[pick_o.way])
    else $error("salc_pick: fill victim is not invalid");

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_tags_unit.sv =====
// Top level of the set-associative LRU write-back cache tag store.
// Depends on salc_pkg, salc_ram and salc_pick.
`default_nettype none

//   A transaction is accepted at a rising edge where start_i is high and
//   busy_o is low. It carries the opcode (read or write), the set index, the
//   tag and the recency stamp of one access.
//   Its result appears on hit_o, way_o, writeback_o and evicted_tag_o for
//   exactly one cycle, marked by done_o. The receiver cannot hold it off,
//   so nothing here ever waits on the output side.
//   Timing: the set's tag memory row is read in the cycle of acceptance,
//   searched and written back in the following cycle, and the result is
//   strobed in the cycle after that. Each transaction therefore keeps the
//   block busy through its lookup state only, so the next transaction can
//   be accepted while the result of the last one is strobed.
//   This busy time is set by the read-modify-write of the registered-read
//   tag memory: the next lookup reads the row only once the previous write
//   has landed, so no forwarding path is needed.
//   The ways_in_use register is written through cfg_valid_i/cfg_data_i,
//   which is always ready; it should only be written while idle.
//   Reset clears the valid bits (held in flip-flops, one per line) and sets
//   ways_in_use to four. Tags, stamps and dirty bits in the memory are left
//   as they are, since they are only looked at for valid lines, so no
//   clearing pass is needed and the block is ready straight after reset.
module set_assoc_lru_cache_tags_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic                             opcode_i,
  input  wire logic [5:0]                       set_index_i,
  input  wire logic [salc_pkg::TAG_BITS-1:0]    tag_i,
  input  wire logic [salc_pkg::STAMP_BITS-1:0]  access_stamp_i,
  output logic                                  done_o,
  output logic                                  hit_o,
  output logic [1:0]                            way_o,
  output logic                                  writeback_o,
  output logic [salc_pkg::TAG_BITS-1:0]         evicted_tag_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [salc_pkg::CFG_BITS-1:0]    cfg_data_i
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;

  logic [salc_pkg::CFG_BITS-1:0] ways_q;
  logic [salc_pkg::CFG_BITS-1:0] active;

  // Captured transaction.
  logic                            op_q;
  logic [salc_pkg::SET_BITS-1:0]   set_q;
  logic [salc_pkg::TAG_BITS-1:0]   tag_q;
  logic [salc_pkg::STAMP_BITS-1:0] stamp_q;

  logic [salc_pkg::SETS-1:0][salc_pkg::WAYS-1:0] valid_q;

  logic                          accept;
  logic                          ram_we;
  logic [salc_pkg::ROW_BITS-1:0] ram_rdata;
  logic [salc_pkg::ROW_BITS-1:0] ram_wdata;
  salc_pkg::row_t                row_rd;
  salc_pkg::row_t                row_wr;
  salc_pkg::pick_t               pick;
  salc_pkg::line_t               victim;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign ram_we      = (state_q == ST_LOOKUP);

  // Zero behaves as one way, anything beyond the cache's ways as all of them.
  always_comb begin
    if (ways_q == '0) begin
      active = salc_pkg::CFG_BITS'(1);
    end else if (int'(ways_q) > salc_pkg::WAYS) begin
      active = salc_pkg::CFG_BITS'(salc_pkg::WAYS);
    end else begin
      active = ways_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= salc_pkg::WAYS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ways_q <= cfg_data_i;
    end
  end

  // The low index bits select the set; with 64 sets that is all six bits, so no index is out of range.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      set_q   <= set_index_i[salc_pkg::SET_BITS-1:0];
      tag_q   <= tag_i;
      stamp_q <= access_stamp_i;
    end
  end

  salc_ram #(
    .WIDTH(salc_pkg::ROW_BITS),
    .DEPTH(salc_pkg::SETS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(set_q),
    .wdata_i(ram_wdata),
    .raddr_i(set_index_i[salc_pkg::SET_BITS-1:0]),
    .rdata_o(ram_rdata)
  );

  assign row_rd = salc_pkg::row_t'(ram_rdata);

  salc_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .row_i   (row_rd),
    .valid_i (valid_q[set_q]),
    .active_i(active),
    .tag_i   (tag_q),
    .pick_o  (pick)
  );

  assign victim = row_rd[pick.way];

  // Only the chosen way changes; the rest of the row is written back as read.
  always_comb begin
    row_wr = row_rd;
    row_wr[pick.way].stamp = stamp_q;
    if (pick.hit) begin
      row_wr[pick.way].dirty = row_rd[pick.way].dirty || (op_q == salc_pkg::OP_WRITE);
    end else begin
      row_wr[pick.way].tag   = tag_q;
      row_wr[pick.way].dirty = (op_q == salc_pkg::OP_WRITE);
    end
  end

  assign ram_wdata = salc_pkg::ROW_BITS'(row_wr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[set_q][pick.way] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      done_o        <= 1'b0;
      hit_o         <= 1'b0;
      way_o         <= '0;
      writeback_o   <= 1'b0;
      evicted_tag_o <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_q       <= ST_IDLE;
          done_o        <= 1'b1;
          hit_o         <= pick.hit;
          way_o         <= 2'(pick.way);
          writeback_o   <= !pick.hit && pick.victim_valid && victim.dirty;
          evicted_tag_o <= (!pick.hit && pick.victim_valid) ? victim.tag : '0;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Each accepted transaction occupies the lookup cycle next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOOKUP))
    else $error("salc: accepted transaction did not reach lookup");

  // Result strobes never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("salc: result strobed twice");

  // A result is strobed in the cycle after the lookup, with the block idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |=> (done_o && !busy_o))
    else $error("salc: lookup without result");

  // A hit never reports an eviction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (!writeback_o && evicted_tag_o == '0))
    else $error("salc: hit reported an eviction");

endmodule

`default_nettype wire

// ===== tb/salc_tags_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the cache tag store: keeps its own copy of the tags, valid,
// dirty and stamp state and compares every result. Depends on salc_pkg.
module salc_tags_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic                             busy_o,
  input  wire logic                             opcode_i,
  input  wire logic [5:0]                       set_index_i,
  input  wire logic [salc_pkg::TAG_BITS-1:0]    tag_i,
  input  wire logic [salc_pkg::STAMP_BITS-1:0]  access_stamp_i,
  input  wire logic                             done_o,
  input  wire logic                             hit_o,
  input  wire logic [1:0]                       way_o,
  input  wire logic                             writeback_o,
  input  wire logic [salc_pkg::TAG_BITS-1:0]    evicted_tag_o,
  input  wire logic                             cfg_valid_i,
  input  wire logic                             cfg_ready_o,
  input  wire logic [salc_pkg::CFG_BITS-1:0]    cfg_data_i,
  output int                                    error_count_o,
  output int                                    outstanding_o
);
  import salc_pkg::*;

  typedef struct packed {
    logic                hit;
    logic [1:0]          way;
    logic                writeback;
    logic [TAG_BITS-1:0] evicted_tag;
  } lookup_t;

  logic [TAG_BITS-1:0]   line_tag   [SETS*WAYS];
  logic [STAMP_BITS-1:0] line_stamp [SETS*WAYS];
  bit                    line_valid [SETS*WAYS];
  bit                    line_dirty [SETS*WAYS];
  logic [CFG_BITS-1:0]   ways_cfg;
  lookup_t               lookup_q [$];
  int                    errors;

  // Looks up one access in the model store, updates it and returns the outcome.
  function automatic lookup_t cache_lookup(input logic op, input logic [5:0] set_idx,
                                           input logic [TAG_BITS-1:0] tg,
                                           input logic [STAMP_BITS-1:0] st);
    lookup_t               res;
    int                    active, base, idx, w, victim;
    logic [STAMP_BITS-1:0] oldest;
    res = '0;
    active = (ways_cfg == 0) ? 1 : ((int'(ways_cfg) > WAYS) ? WAYS : int'(ways_cfg));
    base = (int'(set_idx) % SETS) * WAYS;
    for (w = 0; w < active && !res.hit; w++) begin
      idx = base + w;
      if (line_valid[idx] && line_tag[idx] == tg) begin
        line_stamp[idx] = st;
        if (op == OP_WRITE) line_dirty[idx] = 1'b1;
        res.hit = 1'b1;
        res.way = 2'(w);
      end
    end
    if (res.hit) return res;
    // Lowest invalid way first, otherwise the lowest way with the oldest stamp.
    victim = -1;
    for (w = active - 1; w >= 0; w--) begin
      if (!line_valid[base + w]) victim = w;
    end
    if (victim < 0) begin
      victim = 0;
      oldest = line_stamp[base];
      for (w = 1; w < active; w++) begin
        if (line_stamp[base + w] < oldest) begin
          oldest = line_stamp[base + w];
          victim = w;
        end
      end
    end
    idx = base + victim;
    res.way = 2'(victim);
    if (line_valid[idx]) begin
      res.writeback   = line_dirty[idx];
      res.evicted_tag = line_tag[idx];
    end
    line_tag[idx]   = tg;
    line_valid[idx] = 1'b1;
    line_dirty[idx] = (op == OP_WRITE);
    line_stamp[idx] = st;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    int      i;
    if (!rst_ni) begin
      for (i = 0; i < SETS*WAYS; i++) begin
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
      end
      ways_cfg = WAYS_RESET;
      lookup_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) ways_cfg = cfg_data_i;
      if (start_i && !busy_o)
        lookup_q.push_back(cache_lookup(opcode_i, set_index_i, tag_i, access_stamp_i));
      if (done_o) begin
        if (lookup_q.size() == 0) begin
          $error("result with no access outstanding");
          errors++;
        end else begin
          want = lookup_q.pop_front();
          if (hit_o !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit_o);
            errors++;
          end
          if (way_o !== want.way) begin
            $error("way: expected %0d, got %0d", want.way, way_o);
            errors++;
          end
          if (writeback_o !== want.writeback) begin
            $error("writeback: expected %0d, got %0d", want.writeback, writeback_o);
            errors++;
          end
          if (evicted_tag_o !== want.evicted_tag) begin
            $error("evicted_tag: expected %0h, got %0h", want.evicted_tag, evicted_tag_o);
            errors++;
          end
        end
      end
    end
    error_count_o <= errors;
    outstanding_o <= lookup_q.size();
  end

endmodule

// ===== tb/tb_set_assoc_lru_cache_tags_unit.sv =====
`timescale 1ns / 1ps
// Top of the cache tag store testbench: clock, reset, access and register stimulus,
// and the verdict. Depends on salc_pkg, set_assoc_lru_cache_tags_unit and salc_tags_checker.
module tb_set_assoc_lru_cache_tags_unit;
  import salc_pkg::*;

  // The limit lies many times above the length of the slowest correct run,
  // sender gaps included.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 85;
  localparam int POOL_TAGS     = 6;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  opcode_i;
  logic [5:0]            set_index_i;
  logic [TAG_BITS-1:0]   tag_i;
  logic [STAMP_BITS-1:0] access_stamp_i;
  logic                  done_o;
  logic                  hit_o;
  logic [1:0]            way_o;
  logic                  writeback_o;
  logic [TAG_BITS-1:0]   evicted_tag_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_BITS-1:0]   cfg_data_i;
  int                    error_count;
  int                    outstanding;
  int                    cycle_count = 0;

  always #1 clk_i = ~clk_i;

  set_assoc_lru_cache_tags_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .set_index_i    (set_index_i),
    .tag_i          (tag_i),
    .access_stamp_i (access_stamp_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .way_o          (way_o),
    .writeback_o    (writeback_o),
    .evicted_tag_o  (evicted_tag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  salc_tags_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .set_index_i    (set_index_i),
    .tag_i          (tag_i),
    .access_stamp_i (access_stamp_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .way_o          (way_o),
    .writeback_o    (writeback_o),
    .evicted_tag_o  (evicted_tag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .error_count_o  (error_count),
    .outstanding_o  (outstanding)
  );

  // Watchdog: a hung handshake or a result that never turns up ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_set_assoc_lru_cache_tags_unit: errors");
      $finish;
    end
  end

  // Presents one access at the falling edge and holds it until the block takes it.
  // start_i is left high, so back-to-back transactions need no extra assignment.
  task automatic issue_access(input logic op, input logic [5:0] set_idx,
                              input logic [TAG_BITS-1:0] tg, input logic [STAMP_BITS-1:0] st);
    @(negedge clk_i);
    start_i        <= 1'b1;
    opcode_i       <= op;
    set_index_i    <= set_idx;
    tag_i          <= tg;
    access_stamp_i <= st;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Sender gap of a given number of cycles.
  task automatic pause_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Waits until every transaction has produced its result, then lets the pipeline settle.
  task automatic wait_idle();
    pause_sender(1);
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Writes the ways_in_use register; the caller makes sure the block is idle.
  task automatic write_ways(input logic [CFG_BITS-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_BITS-1:0]   phase_ways [PHASES];
    logic [TAG_BITS-1:0]   tag_pool [POOL_TAGS];
    logic [STAMP_BITS-1:0] stamp_now;
    logic [STAMP_BITS-1:0] st;
    logic [TAG_BITS-1:0]   tg;
    logic [5:0]            set_base;
    logic [5:0]            set_idx;
    int                    burst_left;
    int                    pick;
    int                    p, n, k;

    phase_ways = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4, 3'd1};
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    opcode_i       = OP_READ;
    set_index_i    = '0;
    tag_i          = '0;
    access_stamp_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting from the reset value of four ways.
    // Fill set 0, hit on tag 0 and refresh it, then make way 1 dirty with a write hit.
    issue_access(OP_WRITE, 6'd0, 20'h00000, 32'd10);
    issue_access(OP_READ,  6'd0, 20'hFFFFF, 32'd11);
    issue_access(OP_WRITE, 6'd0, 20'h12345, 32'd12);
    issue_access(OP_READ,  6'd0, 20'h54321, 32'd13);
    issue_access(OP_READ,  6'd0, 20'h00000, 32'd20);
    issue_access(OP_WRITE, 6'd0, 20'hFFFFF, 32'd21);
    // Misses on a full set: the dirty way 2 goes first with a writeback, then clean way 3.
    issue_access(OP_READ,  6'd0, 20'hABCDE, 32'd22);
    issue_access(OP_WRITE, 6'd0, 20'h0F0F0, 32'd23);
    // Highest set with the stamp extremes; equal oldest stamps pick the lowest way.
    issue_access(OP_READ,  6'd63, 20'h00001, 32'h0000_0000);
    issue_access(OP_READ,  6'd63, 20'h00002, 32'h0000_0000);
    issue_access(OP_WRITE, 6'd63, 20'h00003, 32'hFFFF_FFFF);
    issue_access(OP_READ,  6'd63, 20'h00004, 32'h0000_0000);
    issue_access(OP_WRITE, 6'd63, 20'h00005, 32'd5);
    issue_access(OP_READ,  6'd63, 20'h00006, 32'd6);
    wait_idle();

    // Two ways in use, then a register value of zero, which behaves as one way:
    // tag 0x222 lands in way 1, then a second copy replaces way 0.
    write_ways(3'd2);
    issue_access(OP_READ,  6'd5, 20'h00111, 32'd100);
    issue_access(OP_WRITE, 6'd5, 20'h00222, 32'd101);
    wait_idle();
    write_ways(3'd0);
    issue_access(OP_WRITE, 6'd5, 20'h00222, 32'd102);
    wait_idle();
    // Seven behaves as four: both copies match and the lowest way must hit.
    write_ways(3'd7);
    issue_access(OP_READ,  6'd5, 20'h00222, 32'd103);
    issue_access(OP_READ,  6'd5, 20'h00333, 32'd104);
    wait_idle();

    // Random part. Each phase uses a handful of sets and a small tag pool so that hits,
    // evictions and writebacks are common; a minority of transactions use any set and tag.
    burst_left = 0;
    stamp_now  = 32'd1000;
    for (p = 0; p < PHASES; p++) begin
      write_ways(phase_ways[p]);
      for (k = 0; k < POOL_TAGS; k++) tag_pool[k] = TAG_BITS'($urandom);
      set_base = 6'($urandom_range(0, 63));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          pause_sender($urandom_range(1, 5));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;

        if ($urandom_range(0, 99) < 80) set_idx = set_base ^ 6'($urandom_range(0, 3));
        else                            set_idx = 6'($urandom);
        if ($urandom_range(0, 99) < 85) tg = tag_pool[$urandom_range(0, POOL_TAGS - 1)];
        else                            tg = TAG_BITS'($urandom);

        // Mostly a rising stamp with repeats, so that ties and true LRU order both
        // occur; now and then an arbitrary value or one of the extremes.
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          stamp_now = stamp_now + STAMP_BITS'($urandom_range(0, 3));
          st = stamp_now;
        end else if (pick < 92) begin
          st = $urandom;
        end else begin
          st = $urandom_range(0, 1) ? '1 : '0;
        end

        issue_access(1'($urandom_range(0, 1)), set_idx, tg, st);
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("tb_set_assoc_lru_cache_tags_unit: clean");
    end else begin
      $display("tb_set_assoc_lru_cache_tags_unit: errors");
    end
    $finish;
  end

endmodule

// ===== set_assoc_lru_cache_tags_unit.f =====
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_pick.sv
rtl/set_assoc_lru_cache_tags_unit.sv
tb/salc_tags_checker.sv
tb/tb_set_assoc_lru_cache_tags_unit.sv
